// ===== rtl/pllt_pkg.sv =====
package pllt_pkg;

    // Field widths
    localparam int FREQ_W   = 32;
    localparam int REF_W    = 27;
    localparam int BASE_W   = 8;
    localparam int CAP_W    = 6;
    localparam int INT_W    = 9;
    localparam int FRAC_W   = 23;
    localparam int BAND_W   = 6;
    localparam int STATUS_W = 3;
    localparam int CMP_W    = 2;

    // Largest multiplier is 16, so the product grows by four bits
    localparam int PROD_W   = FREQ_W + 4;

    localparam logic [REF_W-1:0] REF_RESET = 27'd26000000;

    // Request kinds
    localparam logic REQ_TUNE    = 1'b0;
    localparam logic REQ_READING = 1'b1;

    // Comparator codes
    localparam logic [CMP_W-1:0] CMP_NORMAL  = 2'd0;
    localparam logic [CMP_W-1:0] CMP_LOW     = 2'd1;
    localparam logic [CMP_W-1:0] CMP_HIGH    = 2'd2;
    localparam logic [CMP_W-1:0] CMP_INVALID = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_CMP   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_WINDOW = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IDLE      = 3'd4;

    // Band edges: band k covers (edge[k], edge[k+1]]
    localparam int NUM_EDGES = 17;
    localparam int NUM_BANDS = 16;
    localparam int EDGE_IW   = 5;
    localparam logic [EDGE_IW-1:0] EDGE_LAST = 5'd16;

    localparam logic [FREQ_W-1:0] BAND_EDGE [NUM_EDGES] = '{
        32'd232500000,  32'd285625000,  32'd336875000,  32'd405000000,
        32'd465000000,  32'd571250000,  32'd673750000,  32'd810000000,
        32'd930000000,  32'd1142500000, 32'd1347500000, 32'd1620000000,
        32'd1860000000, 32'd2285000000, 32'd2695000000, 32'd3240000000,
        32'd3720000000
    };

    localparam logic [BAND_W-1:0] BAND_SEL [NUM_BANDS] = '{
        6'h27, 6'h2f, 6'h37, 6'h3f, 6'h26, 6'h2e, 6'h36, 6'h3e,
        6'h25, 6'h2d, 6'h35, 6'h3d, 6'h24, 6'h2c, 6'h34, 6'h3c
    };

    // Sequencer states
    typedef enum logic [1:0] {
        CS_IDLE,
        CS_BAND,
        CS_DIV
    } ctl_state_t;

    // Capacitor sweep phases
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_NORM,
        PH_LOW
    } phase_t;

    // One result transaction
    typedef struct packed {
        logic [INT_W-1:0]    int_divider;
        logic [FRAC_W-1:0]   frac_divider;
        logic [BAND_W-1:0]   band_code;
        logic [CAP_W-1:0]    cap_setting;
        logic [BASE_W-1:0]   target_base;
        logic [STATUS_W-1:0] status;
        logic                done_res;
    } result_t;

endpackage

// ===== rtl/pllt_if.sv =====
interface pllt_req_if;
    import pllt_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [FREQ_W-1:0] out_freq_hz;
    logic [BASE_W-1:0] register_base;
    logic [CMP_W-1:0]  comparator;

    modport source (
        output valid, req_type, out_freq_hz, register_base, comparator,
        input  ready
    );

    modport sink (
        input  valid, req_type, out_freq_hz, register_base, comparator,
        output ready
    );
endinterface

interface pllt_res_if;
    import pllt_pkg::*;

    logic                valid;
    logic                ready;
    logic [INT_W-1:0]    int_divider;
    logic [FRAC_W-1:0]   frac_divider;
    logic [BAND_W-1:0]   band_code;
    logic [CAP_W-1:0]    cap_setting;
    logic [BASE_W-1:0]   target_base;
    logic [STATUS_W-1:0] status;
    logic                done_res;

    modport source (
        output valid, int_divider, frac_divider, band_code, cap_setting,
               target_base, status, done_res,
        input  ready
    );

    modport sink (
        input  valid, int_divider, frac_divider, band_code, cap_setting,
               target_base, status, done_res,
        output ready
    );
endinterface

// ===== rtl/pllt_div.sv =====
module pllt_div #(
    parameter int FRAC_BITS = 23
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       start,
    input  logic [pllt_pkg::PROD_W+FRAC_BITS-1:0]      dividend,
    input  logic [pllt_pkg::REF_W-1:0]                 divisor,
    output logic [pllt_pkg::INT_W+FRAC_BITS-1:0]       quotient,
    output logic                                       done
);
    import pllt_pkg::*;

    localparam int DW    = PROD_W + FRAC_BITS;
    localparam int QW    = INT_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    num_reg, num_next;
    logic [REF_W-1:0] den_reg, den_next;
    logic [REF_W-1:0] rem_reg, rem_next;
    logic [QW-1:0]    quo_reg, quo_next;

    logic [REF_W:0]   partial;
    logic [REF_W:0]   diff;
    logic             ge;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    // One restoring step per cycle: bring down a bit, subtract if it fits
    always_comb
    begin
        partial = {rem_reg, num_reg[DW-1]};
        diff    = partial - {1'b0, den_reg};
        ge      = (partial >= {1'b0, den_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DW);
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[DW-2:0], 1'b0};
            rem_next = ge ? diff[REF_W-1:0] : partial[REF_W-1:0];
            quo_next = {quo_reg[QW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== rtl/pll_tune_vco_cap_sweep_unit.sv =====
// PLL tuning controller. A tune request (req_type 0) selects the band code,
// then computes the integer and fractional divider as one bit-serial long
// division of (multiplier * frequency) << FRAC_BITS by ref_clock_hz; the
// band search checks one edge per cycle, and the divider result is then
// handed over to the result register. Each comparator reading (req_type 1)
// advances the capacitor sweep and its answer is registered for the result
// channel. One transaction is worked on at a time; the next is taken as soon
// as the result register is free or is being emptied. ref_clock_hz is written
// through cfg_wr_en / cfg_wr_data and should change only while no tune request
// is in flight.
module pll_tune_vco_cap_sweep_unit #(
    parameter int CAP_STEPS = 64,
    parameter int FRAC_BITS = 23
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [pllt_pkg::REF_W-1:0]   cfg_wr_data,
    pllt_req_if.sink                     req,
    pllt_res_if.source                   res
);
    import pllt_pkg::*;

    localparam int DW = PROD_W + FRAC_BITS;
    localparam int QW = INT_W + FRAC_BITS;
    localparam logic [CAP_W-1:0] CAP_LAST = CAP_W'(CAP_STEPS - 1);

    ctl_state_t         state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [CAP_W-1:0]   idx_reg, idx_next;
    logic [CAP_W-1:0]   ws_reg, ws_next;
    logic [CAP_W-1:0]   we_reg, we_next;
    logic [BASE_W-1:0]  base_reg, base_next;
    logic [REF_W-1:0]   ref_reg;
    logic [FREQ_W-1:0]  f_reg, f_next;
    logic [EDGE_IW-1:0] edge_idx_reg, edge_idx_next;
    logic [EDGE_IW-1:0] above_reg, above_next;
    logic [BAND_W-1:0]  code_reg, code_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    logic               in_acc;
    logic               div_start;
    logic [DW-1:0]      div_num;
    logic [QW-1:0]      div_quo;
    logic               div_done;

    logic [EDGE_IW-1:0] above_inc;
    logic               in_range;
    logic [3:0]         band_k;
    logic [2:0]         mult_sh;
    logic [PROD_W-1:0]  prod;
    phase_t             ph1;
    logic [CAP_W-1:0]   ws1, we1;
    logic [CAP_W:0]     mid_sum;

    assign req.ready = (state_reg == CS_IDLE) && (!out_valid_reg || res.ready);
    assign in_acc    = req.valid && req.ready;

    // Band search arithmetic and the shifted product for the divider
    assign above_inc = above_reg + EDGE_IW'(f_reg > BAND_EDGE[edge_idx_reg]);
    assign band_k    = 4'(above_inc - 1'b1);
    assign in_range  = (above_inc != '0) && (above_inc <= EDGE_LAST) && (ref_reg != '0);
    assign mult_sh   = 3'd4 - {1'b0, band_k[3:2]};
    assign prod      = PROD_W'(f_reg) << mult_sh;
    assign div_num   = {prod, {FRAC_BITS{1'b0}}};

    pllt_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (ref_reg),
        .quotient (div_quo),
        .done     (div_done)
    );

    // Control and sweep state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            phase_reg     <= PH_IDLE;
            idx_reg       <= '0;
            ws_reg        <= '0;
            we_reg        <= '0;
            base_reg      <= '0;
            ref_reg       <= REF_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            ws_reg        <= ws_next;
            we_reg        <= we_next;
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                ref_reg <= cfg_wr_data;
            end
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        f_reg        <= f_next;
        edge_idx_reg <= edge_idx_next;
        above_reg    <= above_next;
        code_reg     <= code_next;
        out_reg      <= out_next;
    end

    // Next state and results
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        ws_next        = ws_reg;
        we_next        = we_reg;
        base_next      = base_reg;
        f_next         = f_reg;
        edge_idx_next  = edge_idx_reg;
        above_next     = above_reg;
        code_next      = code_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_next       = out_reg;
        div_start      = 1'b0;
        ph1            = phase_reg;
        ws1            = ws_reg;
        we1            = we_reg;
        mid_sum        = '0;

        case (state_reg)
            CS_IDLE:
            begin
                if (in_acc && (req.req_type == REQ_TUNE))
                begin
                    // Latch the request and start the band search
                    base_next     = req.register_base;
                    phase_next    = PH_IDLE;
                    f_next        = req.out_freq_hz;
                    edge_idx_next = '0;
                    above_next    = '0;
                    state_next    = CS_BAND;
                end
                else if (in_acc)
                begin
                    // Comparator reading: the answer is registered for the result channel
                    out_valid_next       = 1'b1;
                    out_next             = '0;
                    out_next.target_base = base_reg;
                    if (phase_reg == PH_IDLE)
                    begin
                        out_next.status = ST_IDLE;
                    end
                    else if (req.comparator == CMP_INVALID)
                    begin
                        phase_next        = PH_IDLE;
                        out_next.status   = ST_BAD_CMP;
                        out_next.done_res = 1'b1;
                    end
                    else
                    begin
                        if ((req.comparator == CMP_LOW) && (phase_reg == PH_NORM))
                        begin
                            we1 = idx_reg - 1'b1;
                            ph1 = PH_LOW;
                        end
                        else if ((req.comparator == CMP_NORMAL) && (phase_reg == PH_HIGH))
                        begin
                            ws1 = idx_reg;
                            ph1 = PH_NORM;
                        end

                        if (idx_reg == CAP_LAST)
                        begin
                            // Last step: close the window and report
                            if (ph1 == PH_NORM)
                            begin
                                we1 = CAP_LAST;
                            end
                            phase_next        = PH_IDLE;
                            out_next.done_res = 1'b1;
                            if (ph1 == PH_HIGH)
                            begin
                                out_next.status = ST_NO_WINDOW;
                            end
                            else
                            begin
                                mid_sum              = {1'b0, ws1} + {1'b0, we1};
                                out_next.cap_setting = mid_sum[CAP_W:1];
                                out_next.status      = ST_OK;
                            end
                        end
                        else
                        begin
                            // Advance to the next capacitor step
                            phase_next           = ph1;
                            idx_next             = idx_reg + 1'b1;
                            out_next.cap_setting = idx_reg + 1'b1;
                            out_next.status      = ST_OK;
                        end
                        ws_next = ws1;
                        we_next = we1;
                    end
                end
            end

            CS_BAND:
            begin
                // Count band edges below the target, one edge per cycle
                edge_idx_next = edge_idx_reg + 1'b1;
                above_next    = above_inc;
                if (edge_idx_reg == EDGE_LAST)
                begin
                    if (in_range)
                    begin
                        code_next  = BAND_SEL[band_k];
                        div_start  = 1'b1;
                        state_next = CS_DIV;
                    end
                    else
                    begin
                        out_valid_next       = 1'b1;
                        out_next             = '0;
                        out_next.target_base = base_reg;
                        out_next.status      = ST_RANGE;
                        out_next.done_res    = 1'b1;
                        state_next           = CS_IDLE;
                    end
                end
            end

            CS_DIV:
            begin
                // Hold until the divider finishes, then arm the sweep
                if (div_done)
                begin
                    out_valid_next        = 1'b1;
                    out_next              = '0;
                    out_next.int_divider  = div_quo[FRAC_BITS +: INT_W];
                    out_next.frac_divider = FRAC_W'(div_quo[FRAC_BITS-1:0]);
                    out_next.band_code    = code_reg;
                    out_next.target_base  = base_reg;
                    out_next.status       = ST_OK;
                    phase_next            = PH_HIGH;
                    idx_next              = '0;
                    ws_next               = '0;
                    we_next               = '0;
                    state_next            = CS_IDLE;
                end
            end

            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // Drive the result channel
    assign res.valid        = out_valid_reg;
    assign res.int_divider  = out_reg.int_divider;
    assign res.frac_divider = out_reg.frac_divider;
    assign res.band_code    = out_reg.band_code;
    assign res.cap_setting  = out_reg.cap_setting;
    assign res.target_base  = out_reg.target_base;
    assign res.status       = out_reg.status;
    assign res.done_res     = out_reg.done_res;

endmodule
